// ===== hdl/bfnn_pkg.sv =====
// Package for the brute-force nearest-neighbor search block.
// Sizes, field widths, command transaction type and the element conversion helper.
// No dependencies; every other file except bfnn_ram imports it.
package bfnn_pkg;

  // Sizing
  localparam int MAX_REFERENCE_ROWS    = 256;
  localparam int MAX_DESCRIPTOR_LENGTH = 128;
  localparam int ELEMENT_BITS          = 16;

  // Fixed port widths
  localparam int MODE_W    = 2;
  localparam int ELEM_IN_W = 16;
  localparam int CFG_W     = 8;
  localparam int ROW_OUT_W = 8;
  localparam int DIST_W    = 48;

  localparam logic [DIST_W-1:0] DIST_MAX     = '1;
  localparam logic [CFG_W-1:0]  LENGTH_RESET = CFG_W'(128);

  // Derived widths
  localparam int LEN_W     = $clog2(MAX_DESCRIPTOR_LENGTH + 1);
  localparam int POS_W     = (MAX_DESCRIPTOR_LENGTH > 1) ? $clog2(MAX_DESCRIPTOR_LENGTH) : 1;
  localparam int CNT_W     = $clog2(MAX_REFERENCE_ROWS + 1);
  localparam int ROW_W     = (MAX_REFERENCE_ROWS > 1) ? $clog2(MAX_REFERENCE_ROWS) : 1;
  localparam int REF_DEPTH = MAX_REFERENCE_ROWS * MAX_DESCRIPTOR_LENGTH;
  localparam int REF_AW    = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
  localparam int RAW_W     = (ELEMENT_BITS > ELEM_IN_W) ? ELEMENT_BITS : ELEM_IN_W;
  localparam int DIFF_W    = ELEMENT_BITS + 1;
  localparam int SQ_W      = 2 * DIFF_W;
  localparam int SQX_W     = (SQ_W > DIST_W) ? SQ_W : DIST_W;

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef enum logic {
    CMD_LOAD,
    CMD_QUERY
  } cmd_op_t;

  typedef logic        [LEN_W-1:0]        len_t;
  typedef logic        [POS_W-1:0]        pos_t;
  typedef logic        [CNT_W-1:0]        cnt_t;
  typedef logic        [ROW_W-1:0]        row_t;
  typedef logic        [REF_AW-1:0]       ref_addr_t;
  typedef logic signed [ELEMENT_BITS-1:0] elem_t;
  typedef logic        [DIST_W-1:0]       dist_t;

  // One command transaction handed from front to back
  typedef struct packed {
    cmd_op_t   op;
    logic      last;       // query element closes a row
    ref_addr_t ref_addr;   // store address for a load
    pos_t      qry_addr;   // buffer slot for a query element
    elem_t     elem;
    cnt_t      row_count;  // rows stored when the query row closed
    len_t      len;        // active row length
  } cmd_t;

  // Low ELEMENT_BITS of the raw field, read as signed
  function automatic elem_t elem_from_raw(input logic [ELEM_IN_W-1:0] raw);
    logic [RAW_W-1:0] wide;
    wide = RAW_W'(raw);
    return elem_t'(wide[ELEMENT_BITS-1:0]);
  endfunction

endpackage

// ===== hdl/bfnn_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Stand-alone; no package needed.
module bfnn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/bfnn_front.sv =====
// Front end: takes input items and the length register, tracks row positions and
// row count, and turns items into command transactions. Depends on bfnn_pkg.
module bfnn_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bfnn_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bfnn_pkg::MODE_W-1:0]     in_mode,
  input  logic signed [bfnn_pkg::ELEM_IN_W-1:0] in_element,
  output logic                            cmd_push,
  output bfnn_pkg::cmd_t                  cmd_data,
  input  logic                            cmd_full
);
  import bfnn_pkg::*;

  logic [CFG_W-1:0] cfg_len_r;
  cnt_t             row_cnt_r, row_cnt_nxt;
  pos_t             load_pos_r, load_pos_nxt;
  pos_t             qry_pos_r, qry_pos_nxt;
  ref_addr_t        row_base_r, row_base_nxt;
  len_t             act_len;
  logic             in_acc;
  logic             load_end;
  logic             qry_end;

  assign cfg_ready = 1'b1;
  assign in_ready  = !cmd_full;
  assign in_acc    = in_valid && in_ready;

  // Zero length acts as one, oversize clamps to the maximum
  always_comb begin
    if (cfg_len_r == '0) begin
      act_len = LEN_W'(1);
    end else if (int'(cfg_len_r) > MAX_DESCRIPTOR_LENGTH) begin
      act_len = LEN_W'(MAX_DESCRIPTOR_LENGTH);
    end else begin
      act_len = LEN_W'(cfg_len_r);
    end
  end

  assign load_end = (LEN_W'(load_pos_r) + LEN_W'(1)) >= act_len;
  assign qry_end  = (LEN_W'(qry_pos_r) + LEN_W'(1)) >= act_len;

  // Item classification and position bookkeeping
  always_comb begin
    row_cnt_nxt  = row_cnt_r;
    load_pos_nxt = load_pos_r;
    qry_pos_nxt  = qry_pos_r;
    row_base_nxt = row_base_r;
    cmd_push     = 1'b0;

    cmd_data.op        = CMD_LOAD;
    cmd_data.last      = qry_end;
    cmd_data.ref_addr  = row_base_r + REF_AW'(load_pos_r);
    cmd_data.qry_addr  = qry_pos_r;
    cmd_data.elem      = elem_from_raw(in_element);
    cmd_data.row_count = row_cnt_r;
    cmd_data.len       = act_len;

    if (in_acc) begin
      unique case (in_mode)
        MODE_LOAD: begin
          // store full: element dropped
          if (row_cnt_r < CNT_W'(MAX_REFERENCE_ROWS)) begin
            cmd_push = 1'b1;
            if (load_end) begin
              load_pos_nxt = '0;
              row_cnt_nxt  = row_cnt_r + CNT_W'(1);
              row_base_nxt = row_base_r + REF_AW'(MAX_DESCRIPTOR_LENGTH);
            end else begin
              load_pos_nxt = load_pos_r + POS_W'(1);
            end
          end
        end
        MODE_QUERY: begin
          cmd_push    = 1'b1;
          cmd_data.op = CMD_QUERY;
          qry_pos_nxt = qry_end ? '0 : qry_pos_r + POS_W'(1);
        end
        MODE_CLEAR: begin
          row_cnt_nxt  = '0;
          load_pos_nxt = '0;
          row_base_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r  <= LENGTH_RESET;
      row_cnt_r  <= '0;
      load_pos_r <= '0;
      qry_pos_r  <= '0;
      row_base_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_len_r <= cfg_data;
      end
      row_cnt_r  <= row_cnt_nxt;
      load_pos_r <= load_pos_nxt;
      qry_pos_r  <= qry_pos_nxt;
      row_base_r <= row_base_nxt;
    end
  end

endmodule

// ===== hdl/bfnn_cmdq.sv =====
// Short command queue between front and back so each side stalls on its own.
// Depends on bfnn_pkg for the command type and depth.
module bfnn_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bfnn_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output bfnn_pkg::cmd_t pop_data
);
  import bfnn_pkg::*;

  cmd_t                  mem_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMDQ_CNT_W-1:0] cnt_r;
  logic                  do_push, do_pop;

  assign full      = (cnt_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  function automatic logic [CMDQ_PTR_W-1:0] ptr_inc(input logic [CMDQ_PTR_W-1:0] p);
    return (p == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : p + CMDQ_PTR_W'(1);
  endfunction

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CMDQ_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CMDQ_CNT_W'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CMDQ_CNT_W'(CMDQ_DEPTH))
    else $error("command queue fill level above depth");

  a_cnt_push: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(do_push) && !$past(do_pop)) |-> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("command queue fill level missed a push");
`endif

endmodule

// ===== hdl/bfnn_back.sv =====
// Back end: writes reference and query memories, scans all stored rows through a
// pipelined difference/square/accumulate lane, and holds the result register.
// Depends on bfnn_pkg and bfnn_ram.
module bfnn_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cmd_valid,
  output logic                             cmd_pop,
  input  bfnn_pkg::cmd_t                   cmd_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_match_found,
  output logic [bfnn_pkg::ROW_OUT_W-1:0]   out_match_row,
  output logic [bfnn_pkg::DIST_W-1:0]      out_match_distance
);
  import bfnn_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  // Tags that travel alongside the data through the lane
  typedef struct packed {
    logic first;   // first column of a row
    logic lastc;   // last column of a row
    logic lastr;   // last column of the last row
    row_t row;
  } tag_t;

  state_t    state_r;
  cnt_t      scan_cnt_r;
  len_t      scan_len_r;
  row_t      row_r;
  pos_t      col_r;
  ref_addr_t base_r;

  logic      s1_vld_r, s2_vld_r, s3_vld_r, d_vld_r;
  tag_t      s1_tag_r, s2_tag_r, s3_tag_r;
  logic [DIFF_W-1:0] s2_mag_r;
  logic [SQ_W-1:0]   s3_sq_r;
  dist_t     acc_r;
  dist_t     d_dist_r;
  row_t      d_row_r;
  logic      d_lastr_r;
  dist_t     best_dist_r;
  row_t      best_row_r;

  logic                 out_valid_r;
  logic                 out_found_r;
  logic [ROW_OUT_W-1:0] out_row_r;
  dist_t                out_dist_r;

  logic      cmd_block;
  logic      ref_we, qry_we;
  logic      issue, col_end, row_end;
  ref_addr_t ref_raddr;
  elem_t     ref_rd, qry_rd;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        mag;
  logic [SQX_W-1:0]         sq_x;
  dist_t                    sq_sat;
  dist_t                    acc_base;
  logic [DIST_W:0]          acc_sum;
  dist_t                    acc_nxt;
  logic                     better;
  dist_t                    fin_dist;
  row_t                     fin_row;

  // A closing query waits until the previous result has been taken
  assign cmd_block = (cmd_data.op == CMD_QUERY) && cmd_data.last && out_valid_r;
  assign cmd_pop   = (state_r == ST_IDLE) && cmd_valid && !cmd_block;
  assign ref_we    = cmd_pop && (cmd_data.op == CMD_LOAD);
  assign qry_we    = cmd_pop && (cmd_data.op == CMD_QUERY);

  // Scan address generation
  assign issue     = (state_r == ST_SCAN);
  assign col_end   = (LEN_W'(col_r) + LEN_W'(1)) == scan_len_r;
  assign row_end   = (CNT_W'(row_r) + CNT_W'(1)) == scan_cnt_r;
  assign ref_raddr = base_r + REF_AW'(col_r);

  bfnn_ram #(
    .WIDTH(ELEMENT_BITS),
    .DEPTH(REF_DEPTH)
  ) u_ref_ram (
    .clk     (clk),
    .wr_en   (ref_we),
    .wr_addr (cmd_data.ref_addr),
    .wr_data (cmd_data.elem),
    .rd_addr (ref_raddr),
    .rd_data (ref_rd)
  );

  bfnn_ram #(
    .WIDTH(ELEMENT_BITS),
    .DEPTH(MAX_DESCRIPTOR_LENGTH)
  ) u_qry_ram (
    .clk     (clk),
    .wr_en   (qry_we),
    .wr_addr (cmd_data.qry_addr),
    .wr_data (cmd_data.elem),
    .rd_addr (col_r),
    .rd_data (qry_rd)
  );

  // Difference magnitude
  assign diff = DIFF_W'(qry_rd) - DIFF_W'(ref_rd);
  assign mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  // Saturating accumulate
  assign sq_x     = SQX_W'(s3_sq_r);
  assign sq_sat   = (sq_x > SQX_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(sq_x);
  assign acc_base = s3_tag_r.first ? '0 : acc_r;
  assign acc_sum  = {1'b0, acc_base} + {1'b0, sq_sat};
  assign acc_nxt  = acc_sum[DIST_W] ? DIST_MAX : acc_sum[DIST_W-1:0];

  // Best-row compare, first row wins ties
  assign better   = (d_row_r == '0) || (d_dist_r < best_dist_r);
  assign fin_dist = better ? d_dist_r : best_dist_r;
  assign fin_row  = better ? d_row_r : best_row_r;

  // Control, scan counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_cnt_r  <= '0;
      scan_len_r  <= '0;
      row_r       <= '0;
      col_r       <= '0;
      base_r      <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      d_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
      out_found_r <= 1'b0;
      out_row_r   <= '0;
      out_dist_r  <= '0;
    end else begin
      s1_vld_r <= issue;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      d_vld_r  <= s3_vld_r && s3_tag_r.lastc;

      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (qry_we && cmd_data.last) begin
            if (cmd_data.row_count == '0) begin
              // empty set: no match
              out_valid_r <= 1'b1;
              out_found_r <= 1'b0;
              out_row_r   <= '0;
              out_dist_r  <= '0;
            end else begin
              state_r    <= ST_SCAN;
              scan_cnt_r <= cmd_data.row_count;
              scan_len_r <= cmd_data.len;
              row_r      <= '0;
              col_r      <= '0;
              base_r     <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (col_end) begin
            col_r  <= '0;
            row_r  <= row_r + ROW_W'(1);
            base_r <= base_r + REF_AW'(MAX_DESCRIPTOR_LENGTH);
            if (row_end) begin
              state_r <= ST_DRAIN;
            end
          end else begin
            col_r <= col_r + POS_W'(1);
          end
        end
        ST_DRAIN: begin
          if (d_vld_r && d_lastr_r) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            out_found_r <= 1'b1;
            out_row_r   <= ROW_OUT_W'(fin_row);
            out_dist_r  <= fin_dist;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Lane data
  always_ff @(posedge clk) begin
    s1_tag_r <= '{first: (col_r == '0), lastc: col_end, lastr: col_end && row_end,
                  row: row_r};
    s2_tag_r <= s1_tag_r;
    s3_tag_r <= s2_tag_r;
    s2_mag_r <= mag;
    s3_sq_r  <= SQ_W'(s2_mag_r) * SQ_W'(s2_mag_r);
    if (s3_vld_r) begin
      acc_r <= acc_nxt;
    end
    if (s3_vld_r && s3_tag_r.lastc) begin
      d_dist_r  <= acc_nxt;
      d_row_r   <= s3_tag_r.row;
      d_lastr_r <= s3_tag_r.lastr;
    end
    if (d_vld_r) begin
      best_dist_r <= fin_dist;
      best_row_r  <= fin_row;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_match_found    = out_found_r;
  assign out_match_row      = out_row_r;
  assign out_match_distance = out_dist_r;

`ifndef SYNTHESIS
  a_no_result_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !out_valid_r)
    else $error("result pending while a scan runs");

  a_lane_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    d_vld_r |-> (state_r != ST_IDLE))
    else $error("row distance produced outside a scan");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (CNT_W'(row_r) < scan_cnt_r))
    else $error("scan row beyond stored row count");
`endif

endmodule

// ===== hdl/brute_force_nearest_neighbour_top.sv =====
// Top level of the brute-force nearest-neighbor search block.
// Depends on bfnn_pkg, bfnn_front, bfnn_cmdq, bfnn_back (and bfnn_ram through the back).
//
// Load and query elements are accepted and queued (four entries); load elements are
// dropped once all reference rows are stored. Clear items act at once in the front
// end, and items with the unused mode code are dropped. The back end takes queued
// elements while it is idle, at the earliest in the cycle after they were accepted.
// The element that closes a query row starts a scan of all stored rows through a
// single subtract/square/accumulate lane fed by one read port of the reference memory.
// Nothing behind the closing element in the queue is handled until the scan ends, and
// the input stalls once the queue is full. A query that closes while an earlier
// result is still untaken waits for it. With an empty reference set the result is
// flagged as no match. Reset needs no clearing pass: the row count is cleared and the
// memories are only read where written, as long as the length is not raised between
// loading and querying.
module brute_force_nearest_neighbour_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bfnn_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [bfnn_pkg::MODE_W-1:0]           in_mode,
  input  logic signed [bfnn_pkg::ELEM_IN_W-1:0] in_element,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_match_found,
  output logic [bfnn_pkg::ROW_OUT_W-1:0]        out_match_row,
  output logic [bfnn_pkg::DIST_W-1:0]           out_match_distance
);
  import bfnn_pkg::*;

  logic cmd_push, cmd_full, cmd_pop, cmd_valid;
  cmd_t cmd_in, cmd_out;

  bfnn_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_mode    (in_mode),
    .in_element (in_element),
    .cmd_push   (cmd_push),
    .cmd_data   (cmd_in),
    .cmd_full   (cmd_full)
  );

  bfnn_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_valid (cmd_valid),
    .pop_data  (cmd_out)
  );

  bfnn_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_valid          (cmd_valid),
    .cmd_pop            (cmd_pop),
    .cmd_data           (cmd_out),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_match_found    (out_match_found),
    .out_match_row      (out_match_row),
    .out_match_distance (out_match_distance)
  );

endmodule
